>>> design/edge_table_with_hit_test_assert.svh
// ----------------------------------------------------------------------------
// Edge table assertion macros
// Shorthand for the implication and next-cycle checks used by the checker.
// ----------------------------------------------------------------------------
`ifndef EDGE_TABLE_WITH_HIT_TEST_ASSERT_SVH
`define EDGE_TABLE_WITH_HIT_TEST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edge table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ETL_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edge table assertion failed");

`endif

>>> design/etl_pkg.sv
// ----------------------------------------------------------------------------
// Edge table package
// Sizes, opcodes, sequencer states and the segment unit's types.
// ----------------------------------------------------------------------------
`default_nettype none

package etl_pkg;

  localparam int EDGE_SLOTS = 256;
  localparam int SLOT_BITS  = $clog2(EDGE_SLOTS);
  localparam int CNT_BITS   = $clog2(EDGE_SLOTS + 1);
  localparam int POINT_IDS  = 1024;
  localparam int PID_BITS   = $clog2(POINT_IDS);
  localparam int COORD_BITS = 16;
  localparam int PROD_BITS  = 2 * (COORD_BITS + 1);
  localparam int ACC_BITS   = PROD_BITS + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   diff_t;

  typedef enum logic [2:0] {
    OP_SET_POINT    = 3'd0,
    OP_INSERT       = 3'd1,
    OP_REMOVE       = 3'd2,
    OP_REMOVE_TOUCH = 3'd3,
    OP_LOOKUP       = 3'd4,
    OP_HIT          = 3'd5,
    OP_REMOVE_HIT   = 3'd6,
    OP_NOP          = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_PT1,
    S_PT2,
    S_PT3,
    S_SEG,
    S_FINISH
  } state_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    coord_t qx;
    coord_t qy;
  } seg_pts_t;

  typedef struct packed {
    logic done;
    logic hit;
  } seg_stat_t;

endpackage

`default_nettype wire

>>> design/etl_req_if.sv
// ----------------------------------------------------------------------------
// Edge table request channel
// Valid/ready channel that carries one operation item.
// ----------------------------------------------------------------------------
`default_nettype none

interface etl_req_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    opcode;
  logic [etl_pkg::PID_BITS-1:0]  first_point;
  logic [etl_pkg::PID_BITS-1:0]  second_point;
  etl_pkg::coord_t               coord_x;
  etl_pkg::coord_t               coord_y;

  modport source(output valid, opcode, first_point, second_point, coord_x, coord_y,
                 input ready);
  modport sink(input valid, opcode, first_point, second_point, coord_x, coord_y,
               output ready);
endinterface

`default_nettype wire

>>> design/etl_rsp_if.sv
// ----------------------------------------------------------------------------
// Edge table response channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface etl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [etl_pkg::PID_BITS-1:0]  edge_first;
  logic [etl_pkg::PID_BITS-1:0]  edge_second;
  logic [etl_pkg::CNT_BITS-1:0]  edge_total;
  logic                          table_full;

  modport source(output valid, found, edge_first, edge_second, edge_total, table_full,
                 input ready);
  modport sink(input valid, found, edge_first, edge_second, edge_total, table_full,
               output ready);
endinterface

`default_nettype wire

>>> design/etl_seg_test.sv
// ----------------------------------------------------------------------------
// Point-on-segment test unit
// One shared signed multiplier works out the cross and dot products in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module etl_seg_test (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  etl_pkg::seg_pts_t   pts,
  output etl_pkg::seg_stat_t  stat
);

  etl_pkg::diff_t dx, dy, fx, fy, gx, gy;
  etl_pkg::diff_t mul_a, mul_b;
  logic [2:0] step;
  logic       busy;
  logic signed [etl_pkg::PROD_BITS-1:0] prod;
  logic signed [etl_pkg::ACC_BITS-1:0]  cross_p, dot, skew, cm, cp;
  logic on_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 3'd0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 3'd0;
    end else if (busy) begin
      if (step == 3'd5) begin
        busy <= 1'b0;
      end else begin
        step <= step + 3'd1;
      end
    end
  end

  // Operand order: dx*fy, fx*dy, fx*gx, fy*gy.
  always_comb begin
    case (step)
      3'd0: begin mul_a = dx; mul_b = fy; end
      3'd1: begin mul_a = fx; mul_b = dy; end
      3'd2: begin mul_a = fx; mul_b = gx; end
      default: begin mul_a = fy; mul_b = gy; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dx <= etl_pkg::diff_t'(pts.x2) - etl_pkg::diff_t'(pts.x1);
      dy <= etl_pkg::diff_t'(pts.y2) - etl_pkg::diff_t'(pts.y1);
      fx <= etl_pkg::diff_t'(pts.qx) - etl_pkg::diff_t'(pts.x1);
      fy <= etl_pkg::diff_t'(pts.qy) - etl_pkg::diff_t'(pts.y1);
      gx <= etl_pkg::diff_t'(pts.qx) - etl_pkg::diff_t'(pts.x2);
      gy <= etl_pkg::diff_t'(pts.qy) - etl_pkg::diff_t'(pts.y2);
    end
    prod <= mul_a * mul_b;
    case (step)
      3'd1: cross_p <= etl_pkg::ACC_BITS'(prod);
      3'd2: cross_p <= cross_p - etl_pkg::ACC_BITS'(prod);
      3'd3: dot     <= etl_pkg::ACC_BITS'(prod);
      3'd4: dot     <= dot + etl_pkg::ACC_BITS'(prod);
      default: ;
    endcase
  end

  // Stepping the query by one diagonally shifts the cross product by dx - dy.
  assign skew = etl_pkg::ACC_BITS'(dx) - etl_pkg::ACC_BITS'(dy);
  assign cm   = cross_p + skew;
  assign cp   = cross_p - skew;

  always_comb begin
    if (cross_p == 0) begin
      on_line = 1'b1;
    end else if (cross_p > 0) begin
      on_line = (cm <= 0) || (cp <= 0);
    end else begin
      on_line = (cm >= 0) || (cp >= 0);
    end
  end

  assign stat.done = busy && (step == 3'd5);
  assign stat.hit  = on_line && (dot <= 0);

endmodule

`default_nettype wire

>>> design/edge_table_with_hit_test.sv
// ----------------------------------------------------------------------------
// Edge table with point-on-segment hit test
// Holds up to 256 distinct edges and 1024 points; one operation per item.
// ----------------------------------------------------------------------------
//   channel  dir  handshake      payload
//   req      in   valid/ready    opcode, first_point, second_point, coord_x, coord_y
//   rsp      out  valid/ready    found, edge_first, edge_second, edge_total, table_full
//
// Set point and no-op go from IDLE straight to FINISH. Insert, remove, lookup
// and remove-touching walk the slot table: a SCAN step per slot and a CHECK
// step per held edge. A hit test adds, per held edge, PT1 to PT3 for the point
// memory reads and SEG in the shared multiplier unit.
// Reset clears the valid bits and the edge count at once; stored ends and points
// stay undefined until written. A stalled result holds the sequencer in FINISH.
`default_nettype none

module edge_table_with_hit_test (
  input logic         clk,
  input logic         rst,
  etl_req_if.sink     req,
  etl_rsp_if.source   rsp
);

  localparam int PW = etl_pkg::PID_BITS;
  localparam int CW = etl_pkg::COORD_BITS;

  etl_pkg::state_t state, state_next;
  etl_pkg::op_t    op_q, req_op;

  logic [PW-1:0] a_q, b_q;
  etl_pkg::coord_t qx, qy, x1_q, y1_q;

  logic [etl_pkg::SLOT_BITS-1:0] idx, free_idx, match_idx, best_idx, clr_idx;
  logic free_found, match_found, best_found, touch_found;
  logic [2*PW-1:0] pair, ends_q, best_ends;
  logic [etl_pkg::EDGE_SLOTS-1:0] slot_valid;
  logic [etl_pkg::CNT_BITS-1:0]   count, count_fin;

  logic [2*PW-1:0] slot_ends [etl_pkg::EDGE_SLOTS];
  logic [2*CW-1:0] point_mem [etl_pkg::POINT_IDS];
  logic [2*CW-1:0] pt_q;
  logic [PW-1:0]   pt_addr;

  logic out_free, last, is_pair_op, is_hit_op, pair_eq, touch, better;
  logic pt_we, ends_we, seg_start, step_adv, fin, clr_en;
  logic res_found, res_full;
  logic [2*PW-1:0] res_ends;

  logic rsp_valid_q, out_found, out_full;
  logic [PW-1:0] out_first, out_second;
  logic [etl_pkg::CNT_BITS-1:0] out_total;

  etl_pkg::seg_pts_t  seg_pts;
  etl_pkg::seg_stat_t seg_stat;

  assign req_op     = etl_pkg::op_t'(req.opcode);
  assign pair       = {a_q, b_q};
  assign out_free   = !rsp_valid_q || rsp.ready;
  assign last       = idx == etl_pkg::SLOT_BITS'(etl_pkg::EDGE_SLOTS - 1);
  assign is_pair_op = (op_q == etl_pkg::OP_INSERT) || (op_q == etl_pkg::OP_REMOVE) ||
                      (op_q == etl_pkg::OP_LOOKUP);
  assign is_hit_op  = (op_q == etl_pkg::OP_HIT) || (op_q == etl_pkg::OP_REMOVE_HIT);
  assign pair_eq    = ends_q == pair;
  assign touch      = (ends_q[2*PW-1:PW] == a_q) || (ends_q[PW-1:0] == a_q);
  assign better     = !best_found || (ends_q < best_ends);

  assign seg_pts.x1 = x1_q;
  assign seg_pts.y1 = y1_q;
  assign seg_pts.x2 = pt_q[2*CW-1:CW];
  assign seg_pts.y2 = pt_q[CW-1:0];
  assign seg_pts.qx = qx;
  assign seg_pts.qy = qy;

  etl_seg_test u_seg (
    .clk   (clk),
    .rst   (rst),
    .start (seg_start),
    .pts   (seg_pts),
    .stat  (seg_stat)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      etl_pkg::S_IDLE: begin
        if (req.valid) begin
          if (req_op == etl_pkg::OP_SET_POINT || req_op == etl_pkg::OP_NOP) begin
            state_next = etl_pkg::S_FINISH;
          end else begin
            state_next = etl_pkg::S_SCAN;
          end
        end
      end
      etl_pkg::S_SCAN: begin
        if (slot_valid[idx]) begin
          state_next = etl_pkg::S_CHECK;
        end else if (last) begin
          state_next = etl_pkg::S_FINISH;
        end
      end
      etl_pkg::S_CHECK: begin
        if (is_hit_op) begin
          state_next = etl_pkg::S_PT1;
        end else if ((is_pair_op && pair_eq) || last) begin
          state_next = etl_pkg::S_FINISH;
        end else begin
          state_next = etl_pkg::S_SCAN;
        end
      end
      etl_pkg::S_PT1: state_next = etl_pkg::S_PT2;
      etl_pkg::S_PT2: state_next = etl_pkg::S_PT3;
      etl_pkg::S_PT3: state_next = etl_pkg::S_SEG;
      etl_pkg::S_SEG: begin
        if (seg_stat.done) begin
          state_next = last ? etl_pkg::S_FINISH : etl_pkg::S_SCAN;
        end
      end
      etl_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = etl_pkg::S_IDLE;
        end
      end
      default: state_next = etl_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    req.ready = state == etl_pkg::S_IDLE;
    pt_we     = (state == etl_pkg::S_IDLE) && req.valid && (req_op == etl_pkg::OP_SET_POINT);
    pt_addr   = (state == etl_pkg::S_PT2) ? ends_q[PW-1:0] : ends_q[2*PW-1:PW];
    seg_start = state == etl_pkg::S_PT3;
    fin       = (state == etl_pkg::S_FINISH) && out_free;
    step_adv  = ((state == etl_pkg::S_SCAN) && !slot_valid[idx]) ||
                ((state == etl_pkg::S_CHECK) && !is_hit_op && !(is_pair_op && pair_eq)) ||
                ((state == etl_pkg::S_SEG) && seg_stat.done);
  end

  // Result and table update applied when the operation finishes (remove-touching clears slots in CHECK).
  always_comb begin
    res_found = 1'b0;
    res_full  = 1'b0;
    res_ends  = '0;
    count_fin = count;
    clr_en    = 1'b0;
    clr_idx   = match_idx;
    ends_we   = 1'b0;
    case (op_q)
      etl_pkg::OP_INSERT: begin
        if (match_found) begin
          res_found = 1'b1;
          res_ends  = pair;
        end else if (free_found) begin
          res_found = 1'b1;
          res_ends  = pair;
          count_fin = count + 1'b1;
          ends_we   = fin;
        end else begin
          res_full = 1'b1;
        end
      end
      etl_pkg::OP_REMOVE, etl_pkg::OP_LOOKUP: begin
        if (match_found) begin
          res_found = 1'b1;
          res_ends  = pair;
          if (op_q == etl_pkg::OP_REMOVE) begin
            count_fin = count - 1'b1;
            clr_en    = fin;
          end
        end
      end
      etl_pkg::OP_REMOVE_TOUCH: res_found = touch_found;
      etl_pkg::OP_HIT, etl_pkg::OP_REMOVE_HIT: begin
        if (best_found) begin
          res_found = 1'b1;
          res_ends  = best_ends;
          clr_idx   = best_idx;
          if (op_q == etl_pkg::OP_REMOVE_HIT) begin
            count_fin = count - 1'b1;
            clr_en    = fin;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ends_we) begin
      slot_ends[free_idx] <= pair;
    end
    ends_q <= slot_ends[idx];
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      point_mem[req.first_point] <= {req.coord_x, req.coord_y};
    end
    pt_q <= point_mem[pt_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= etl_pkg::S_IDLE;
      slot_valid  <= '0;
      count       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state <= state_next;

      if (state == etl_pkg::S_IDLE && req.valid) begin
        op_q        <= req_op;
        a_q         <= req.first_point;
        b_q         <= req.second_point;
        qx          <= req.coord_x;
        qy          <= req.coord_y;
        idx         <= '0;
        free_found  <= 1'b0;
        match_found <= 1'b0;
        best_found  <= 1'b0;
        touch_found <= 1'b0;
      end

      if (step_adv) begin
        idx <= idx + 1'b1;
      end

      if (state == etl_pkg::S_SCAN && !slot_valid[idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end

      if (state == etl_pkg::S_CHECK) begin
        if (is_pair_op && pair_eq) begin
          match_found <= 1'b1;
          match_idx   <= idx;
        end
        if (op_q == etl_pkg::OP_REMOVE_TOUCH && touch) begin
          slot_valid[idx] <= 1'b0;
          count           <= count - 1'b1;
          touch_found     <= 1'b1;
        end
      end

      if (state == etl_pkg::S_PT2) begin
        x1_q <= pt_q[2*CW-1:CW];
        y1_q <= pt_q[CW-1:0];
      end

      if (state == etl_pkg::S_SEG && seg_stat.done && seg_stat.hit && better) begin
        best_found <= 1'b1;
        best_ends  <= ends_q;
        best_idx   <= idx;
      end

      if (rsp.ready && !fin) begin
        rsp_valid_q <= 1'b0;
      end

      if (fin) begin
        count       <= count_fin;
        rsp_valid_q <= 1'b1;
        out_found   <= res_found;
        out_full    <= res_full;
        out_first   <= res_ends[2*PW-1:PW];
        out_second  <= res_ends[PW-1:0];
        out_total   <= count_fin;
        if (ends_we) begin
          slot_valid[free_idx] <= 1'b1;
        end
        if (clr_en) begin
          slot_valid[clr_idx] <= 1'b0;
        end
      end
    end
  end

  assign rsp.valid       = rsp_valid_q;
  assign rsp.found       = out_found;
  assign rsp.edge_first  = out_first;
  assign rsp.edge_second = out_second;
  assign rsp.edge_total  = out_total;
  assign rsp.table_full  = out_full;

endmodule

`default_nettype wire

>>> design/etl_checker.sv
// ----------------------------------------------------------------------------
// Edge table port checker
// Watches the top level's channels and checks result items over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "edge_table_with_hit_test_assert.svh"

module etl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          found,
  input logic [etl_pkg::PID_BITS-1:0]  edge_first,
  input logic [etl_pkg::PID_BITS-1:0]  edge_second,
  input logic [etl_pkg::CNT_BITS-1:0]  edge_total,
  input logic                          table_full
);

  // A result item waits until it is taken.
  `ETL_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  // The block works on one item at a time.
  `ETL_ASSERT_NXT(a_one_item, clk, rst, req_valid && req_ready, !req_ready)
  `ETL_ASSERT_IMP(a_total_max, clk, rst, rsp_valid,
                  edge_total <= etl_pkg::CNT_BITS'(etl_pkg::EDGE_SLOTS))
  // A refused insert or a miss reports no edge.
  `ETL_ASSERT_IMP(a_miss_zero, clk, rst, rsp_valid && (!found || table_full),
                  !found && edge_first == '0 && edge_second == '0)

endmodule

bind edge_table_with_hit_test etl_checker u_etl_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .found       (rsp.found),
  .edge_first  (rsp.edge_first),
  .edge_second (rsp.edge_second),
  .edge_total  (rsp.edge_total),
  .table_full  (rsp.table_full)
);

`default_nettype wire
